@@ rtl/core/frsp_pkg.sv @@
// Shared types and constants for the FASTA record stream parser.
// Used by every module of the block; depends on nothing else.
package frsp_pkg;

  // Result kinds carried on the output channel.
  localparam logic [2:0] KIND_NAME    = 3'd0;
  localparam logic [2:0] KIND_COMMENT = 3'd1;
  localparam logic [2:0] KIND_RESIDUE = 3'd2;
  localparam logic [2:0] KIND_END     = 3'd3;
  localparam logic [2:0] KIND_TRUNC   = 3'd4;
  localparam logic [2:0] KIND_NOTFA   = 3'd5;
  localparam logic [2:0] KIND_BADRES  = 3'd6;

  // Characters with a special meaning in the stream.
  localparam logic [7:0] CH_GT     = 8'h3E;  // '>'
  localparam logic [7:0] CH_PIPE   = 8'h7C;  // '|'
  localparam logic [7:0] CH_SLASH  = 8'h2F;  // '/'
  localparam logic [7:0] CH_UNDER  = 8'h5F;  // '_'
  localparam logic [7:0] CH_LBRACE = 8'h7B;  // '{'
  localparam logic [7:0] CH_RBRACE = 8'h7D;  // '}'
  localparam logic [7:0] CH_DASH   = 8'h2D;  // '-'
  localparam logic [7:0] CH_DOT    = 8'h2E;  // '.'
  localparam logic [7:0] CH_COLON  = 8'h3A;  // ':'
  localparam logic [7:0] CH_COMMA  = 8'h2C;  // ','
  localparam logic [7:0] CH_SEMI   = 8'h3B;  // ';'
  localparam logic [7:0] CH_LPAREN = 8'h28;  // '('
  localparam logic [7:0] CH_RPAREN = 8'h29;  // ')'
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  out_byte;
    logic [15:0] record_index;
  } out_item_t;

endpackage

@@ rtl/core/frsp_front.sv @@
// Front part: accepts stream bytes, tracks the parse mode and record count,
// and pushes one raw result per meaningful byte into the queue.
// Depends on frsp_pkg.
module frsp_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  output logic                byte_ready,
  input  frsp_pkg::in_item_t  byte_data,
  input  logic                q_full,
  output logic                q_push,
  output frsp_pkg::out_item_t q_item
);
  import frsp_pkg::*;

  localparam logic [2:0] MODE_SEEK    = 3'd0;
  localparam logic [2:0] MODE_NAME    = 3'd1;
  localparam logic [2:0] MODE_COMMENT = 3'd2;
  localparam logic [2:0] MODE_SEQ     = 3'd3;
  localparam logic [2:0] MODE_DONE    = 3'd4;

  logic [2:0]  mode, mode_next;
  logic [15:0] count, count_next;
  logic [7:0]  b;
  logic        eoi;
  logic        accept;
  logic        is_space;
  logic        is_term;
  logic        seq_skip;
  logic        is_upper, is_lower, is_res;
  logic [7:0]  low;

  assign byte_ready = !q_full;
  assign accept     = byte_valid && byte_ready;
  assign b          = byte_data.data_byte;
  assign eoi        = byte_data.end_of_input;

  always_comb begin
    is_space = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) ||
               (b == CH_VT) || (b == CH_FF) || (b == CH_CR);
    is_term  = is_space || (b == CH_PIPE) || (b == CH_SLASH);
    seq_skip = (b == CH_SPACE) || (b == CH_LF) || (b == CH_CR) || (b == CH_TAB) ||
               ((b >= 8'h30) && (b <= 8'h39));
    is_upper = (b >= 8'h41) && (b <= 8'h5A);
    is_lower = (b >= 8'h61) && (b <= 8'h7A);
    low      = b | 8'h20;
    is_res   = (b == CH_DASH) || (b == CH_DOT) ||
               ((is_upper || is_lower) && (low != 8'h6A) && (low != 8'h6F));
  end

  always_comb begin
    mode_next           = mode;
    count_next          = count;
    q_push              = 1'b0;
    q_item.kind         = KIND_NAME;
    q_item.out_byte     = b;
    q_item.record_index = count;
    if (accept) begin
      case (mode)
        MODE_SEEK: begin
          if (eoi) begin
            mode_next       = MODE_DONE;
            q_push          = 1'b1;
            q_item.kind     = KIND_NOTFA;
            q_item.out_byte = 8'h00;
          end else if (b == CH_GT) begin
            mode_next = MODE_NAME;
          end else if (!is_space) begin
            mode_next   = MODE_DONE;
            q_push      = 1'b1;
            q_item.kind = KIND_NOTFA;
          end
        end
        MODE_NAME: begin
          if (eoi) begin
            mode_next       = MODE_DONE;
            q_push          = 1'b1;
            q_item.kind     = KIND_TRUNC;
            q_item.out_byte = 8'h00;
          end else if (is_term) begin
            mode_next = (b == CH_LF) ? MODE_SEQ : MODE_COMMENT;
          end else begin
            q_push      = 1'b1;
            q_item.kind = KIND_NAME;
          end
        end
        MODE_COMMENT: begin
          if (eoi) begin
            mode_next       = MODE_DONE;
            q_push          = 1'b1;
            q_item.kind     = KIND_TRUNC;
            q_item.out_byte = 8'h00;
          end else if (b == CH_LF) begin
            mode_next = MODE_SEQ;
          end else begin
            q_push      = 1'b1;
            q_item.kind = KIND_COMMENT;
          end
        end
        MODE_SEQ: begin
          if (eoi || (b == CH_GT)) begin
            mode_next       = eoi ? MODE_DONE : MODE_NAME;
            q_push          = 1'b1;
            q_item.kind     = KIND_END;
            q_item.out_byte = 8'h00;
            if (count != 16'hFFFF) begin
              count_next = count + 16'd1;
            end
          end else if (!seq_skip) begin
            q_push = 1'b1;
            if (is_res) begin
              q_item.kind = KIND_RESIDUE;
            end else begin
              mode_next   = MODE_DONE;
              q_item.kind = KIND_BADRES;
            end
          end
        end
        default: begin
          mode_next = mode;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_SEEK;
      count <= 16'd0;
    end else begin
      mode  <= mode_next;
      count <= count_next;
    end
  end

endmodule

@@ rtl/core/frsp_queue.sv @@
// Short result queue between the front and back parts.
// Depends on frsp_pkg for the entry type.
module frsp_queue #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  frsp_pkg::out_item_t push_item,
  output logic                full,
  input  logic                pop,
  output logic                not_empty,
  output frsp_pkg::out_item_t head_item
);
  import frsp_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  out_item_t       slots [DEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;
  logic            do_push, do_pop;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

@@ rtl/core/frsp_back.sv @@
// Back part: takes raw results from the queue, applies the name character
// substitutions and holds each result in the output register until transfer.
// Depends on frsp_pkg.
module frsp_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  frsp_pkg::out_item_t q_item,
  output logic                q_pop,
  output logic                result_valid,
  input  logic                result_ready,
  output frsp_pkg::out_item_t result_data
);
  import frsp_pkg::*;

  out_item_t formed;
  logic      load;

  always_comb begin
    formed = q_item;
    if (q_item.kind == KIND_NAME) begin
      if ((q_item.out_byte == CH_COLON) || (q_item.out_byte == CH_COMMA) ||
          (q_item.out_byte == CH_SEMI)) begin
        formed.out_byte = CH_UNDER;
      end else if (q_item.out_byte == CH_LPAREN) begin
        formed.out_byte = CH_LBRACE;
      end else if (q_item.out_byte == CH_RPAREN) begin
        formed.out_byte = CH_RBRACE;
      end
    end
  end

  assign load  = q_valid && (!result_valid || result_ready);
  assign q_pop = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_data <= formed;
    end
  end

endmodule

@@ rtl/core/fasta_record_stream_parser.sv @@
// FASTA record stream parser, top level.
// Byte channel (byte_valid/byte_ready/byte_data) carries one text byte or an
// end-of-input mark per transfer. Result channel (result_valid/result_ready/
// result_data) carries name, comment and residue characters, record ends and
// the terminal truncated, not-FASTA and bad-residue results.
// Throughput is one byte per cycle while the queue is not full: the front
// updates parse mode and record count in the cycle of the transfer, so bytes
// may arrive back to back. A result passes through two registers: the queue
// entry written at the transfer edge, then the output register, which loads
// once it is free. Bytes that yield no result produce no queue entry.
// When the receiver stalls, results collect in a QUEUE_DEPTH entry queue;
// byte_ready drops only when that queue is full.
// Reset (rst, synchronous) returns to searching for the first '>', clears
// the record count and empties the queue. After a terminal result every
// further byte is accepted and ignored until the next reset.
// Depends on frsp_pkg, frsp_front, frsp_queue and frsp_back.
module fasta_record_stream_parser #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  output logic                byte_ready,
  input  frsp_pkg::in_item_t  byte_data,
  output logic                result_valid,
  input  logic                result_ready,
  output frsp_pkg::out_item_t result_data
);
  import frsp_pkg::*;

  logic      q_full, q_push, q_pop, q_valid;
  out_item_t push_item, head_item;

  frsp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_data  (byte_data),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_item     (push_item)
  );

  frsp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head_item (head_item)
  );

  frsp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_item       (head_item),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_data  (result_data)
  );

endmodule

@@ rtl/core/frsp_checker.sv @@
// Port-level checks for the FASTA record stream parser, bound to the top level.
// Depends on frsp_pkg and fasta_record_stream_parser.
module frsp_checker (
  input logic                clk,
  input logic                rst,
  input logic                result_valid,
  input logic                result_ready,
  input frsp_pkg::out_item_t result_data
);
  import frsp_pkg::*;

  logic        stopped;
  logic        seen;
  logic [15:0] last_index;
  logic        xfer;
  logic        terminal;

  assign xfer     = result_valid && result_ready;
  assign terminal = (result_data.kind == KIND_TRUNC) || (result_data.kind == KIND_NOTFA) ||
                    (result_data.kind == KIND_BADRES);

  always_ff @(posedge clk) begin
    if (rst) begin
      stopped    <= 1'b0;
      seen       <= 1'b0;
      last_index <= 16'd0;
    end else if (xfer) begin
      seen       <= 1'b1;
      last_index <= result_data.record_index;
      if (terminal) begin
        stopped <= 1'b1;
      end
    end
  end

  a_reset_idle: assert property (@(posedge clk) $past(rst) |-> !result_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result_data))
    else $error("stalled result changed or dropped");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result_data.kind <= KIND_BADRES)
    else $error("result kind out of range");

  a_silent_after_error: assert property (@(posedge clk) disable iff (rst)
    stopped |-> !result_valid)
    else $error("result after a terminal error");

  a_index_order: assert property (@(posedge clk) disable iff (rst)
    result_valid && seen |-> result_data.record_index >= last_index)
    else $error("record index went backwards");

endmodule

bind fasta_record_stream_parser frsp_checker u_frsp_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result_data  (result_data)
);

@@ sim/fasta_record_stream_parser_tb.sv @@
`timescale 1ns / 1ps
// Testbench for fasta_record_stream_parser: drives one long FASTA stream through
// the byte channel and checks every result against a cycle-free prediction.
// Depends on frsp_pkg and the parser RTL under rtl/core.
module fasta_record_stream_parser_tb;
  import frsp_pkg::*;

  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_BYTES = 270;

  // Tracks the parse state from accepted bytes and holds the results they owe.
  class parse_tracker;
    typedef enum logic [2:0] {
      SEEK_MARKER, IN_NAME, IN_COMMENT, IN_SEQUENCE, STOPPED
    } mode_e;

    mode_e       mode;
    logic [15:0] records;
    out_item_t   expected_results[$];
    int          failures;

    function new();
      mode = SEEK_MARKER;
      records = '0;
      failures = 0;
    endfunction

    static function bit space_char(logic [7:0] b);
      return b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_VT ||
             b == CH_FF || b == CH_CR;
    endfunction

    // Bytes that the sequence part skips without a result.
    static function bit skip_char(logic [7:0] b);
      return b == CH_SPACE || b == CH_LF || b == CH_CR || b == CH_TAB ||
             (b >= "0" && b <= "9");
    endfunction

    static function bit residue_char(logic [7:0] b);
      logic [7:0] low;
      if (b == CH_DASH || b == CH_DOT) return 1'b1;
      if (b >= "A" && b <= "Z") low = b + 8'd32;
      else if (b >= "a" && b <= "z") low = b;
      else return 1'b0;
      return low != "j" && low != "o";
    endfunction

    function void byte_taken(in_item_t item);
      logic [7:0]  b;
      logic [7:0]  shown;
      logic [2:0]  kind;
      logic [15:0] rec_no;
      bit          produces;
      b = item.data_byte;
      rec_no = records;
      produces = 1'b0;
      shown = '0;
      kind = KIND_NAME;
      case (mode)
        SEEK_MARKER: begin
          if (item.end_of_input) begin
            mode = STOPPED;
            produces = 1'b1;
            kind = KIND_NOTFA;
          end else if (b == CH_GT) begin
            mode = IN_NAME;
          end else if (!space_char(b)) begin
            mode = STOPPED;
            produces = 1'b1;
            kind = KIND_NOTFA;
            shown = b;
          end
        end
        IN_NAME: begin
          if (item.end_of_input) begin
            mode = STOPPED;
            produces = 1'b1;
            kind = KIND_TRUNC;
          end else if (space_char(b) || b == CH_PIPE || b == CH_SLASH) begin
            mode = (b == CH_LF) ? IN_SEQUENCE : IN_COMMENT;
          end else begin
            produces = 1'b1;
            kind = KIND_NAME;
            case (b)
              CH_COLON, CH_COMMA, CH_SEMI: shown = CH_UNDER;
              CH_LPAREN: shown = CH_LBRACE;
              CH_RPAREN: shown = CH_RBRACE;
              default: shown = b;
            endcase
          end
        end
        IN_COMMENT: begin
          if (item.end_of_input) begin
            mode = STOPPED;
            produces = 1'b1;
            kind = KIND_TRUNC;
          end else if (b == CH_LF) begin
            mode = IN_SEQUENCE;
          end else begin
            produces = 1'b1;
            kind = KIND_COMMENT;
            shown = b;
          end
        end
        IN_SEQUENCE: begin
          if (item.end_of_input || b == CH_GT) begin
            produces = 1'b1;
            kind = KIND_END;
            if (records != 16'hFFFF) records++;
            mode = item.end_of_input ? STOPPED : IN_NAME;
          end else if (residue_char(b)) begin
            produces = 1'b1;
            kind = KIND_RESIDUE;
            shown = b;
          end else if (!skip_char(b)) begin
            mode = STOPPED;
            produces = 1'b1;
            kind = KIND_BADRES;
            shown = b;
          end
        end
        default: ;
      endcase
      if (produces)
        expected_results.push_back('{kind: kind, out_byte: shown, record_index: rec_no});
    endfunction

    function void result_seen(out_item_t got);
      out_item_t want;
      if (expected_results.size() == 0) begin
        $error("unexpected result: kind %0d, out_byte 'h%02h, record_index %0d",
               got.kind, got.out_byte, got.record_index);
        failures++;
        return;
      end
      want = expected_results.pop_front();
      if (got.kind !== want.kind) begin
        $error("kind: expected %0d, got %0d", want.kind, got.kind);
        failures++;
      end
      if (got.out_byte !== want.out_byte) begin
        $error("out_byte: expected 'h%02h, got 'h%02h", want.out_byte, got.out_byte);
        failures++;
      end
      if (got.record_index !== want.record_index) begin
        $error("record_index: expected %0d, got %0d", want.record_index, got.record_index);
        failures++;
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      byte_valid = 1'b0;
  logic      byte_ready;
  in_item_t  byte_data = '0;
  logic      result_valid;
  logic      result_ready = 1'b0;
  out_item_t result_data;

  parse_tracker tracker = new();
  in_item_t     stream[$];
  int           send_idle_pct = 0;
  int           stall_pct = 0;
  bit           hold_request = 1'b0;
  int           hold_left = 0;
  int           quiet_cycles = 0;

  fasta_record_stream_parser uut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_ready   (byte_ready),
    .byte_data    (byte_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_data  (result_data)
  );

  always #5 clk = ~clk;

  function automatic in_item_t text_byte(logic [7:0] b);
    return '{data_byte: b, end_of_input: 1'b0};
  endfunction

  function automatic in_item_t eoi_item();
    return '{data_byte: 8'($urandom_range(0, 255)), end_of_input: 1'b1};
  endfunction

  function automatic logic [7:0] pick_comment_stop();
    case ($urandom_range(0, 6))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_VT;
      3: return CH_FF;
      4: return CH_CR;
      5: return CH_PIPE;
      default: return CH_SLASH;
    endcase
  endfunction

  function automatic void add_name();
    logic [7:0] b;
    repeat ($urandom_range(0, 8)) begin
      case ($urandom_range(0, 3))
        0: begin
          case ($urandom_range(0, 4))
            0: b = CH_COLON;
            1: b = CH_COMMA;
            2: b = CH_SEMI;
            3: b = CH_LPAREN;
            default: b = CH_RPAREN;
          endcase
        end
        1: begin
          do b = 8'($urandom_range(0, 255));
          while (parse_tracker::space_char(b) || b == CH_PIPE || b == CH_SLASH);
        end
        default: begin
          do b = 8'($urandom_range(8'h21, 8'h7E));
          while (b == CH_PIPE || b == CH_SLASH);
        end
      endcase
      stream.push_back(text_byte(b));
    end
  endfunction

  function automatic void add_comment();
    logic [7:0] b;
    repeat ($urandom_range(0, 10)) begin
      do b = 8'($urandom_range(0, 255));
      while (b == CH_LF);
      stream.push_back(text_byte(b));
    end
  endfunction

  // Name, an optional terminator and comment, the header's line feed and a sequence; the caller
  // appends whatever closes the record.
  function automatic void add_record();
    logic [7:0] b;
    add_name();
    if ($urandom_range(0, 1)) begin
      stream.push_back(text_byte(pick_comment_stop()));
      add_comment();
    end
    stream.push_back(text_byte(CH_LF));
    repeat ($urandom_range(0, 40)) begin
      case ($urandom_range(0, 9))
        0: b = $urandom_range(0, 1) ? CH_DASH : CH_DOT;
        1, 2: begin
          case ($urandom_range(0, 4))
            0: b = CH_SPACE;
            1: b = CH_LF;
            2: b = CH_CR;
            3: b = CH_TAB;
            default: b = "0" + 8'($urandom_range(0, 9));
          endcase
        end
        default: begin
          do b = 8'($urandom_range("a", "z"));
          while (b == "j" || b == "o");
          if ($urandom_range(0, 1)) b = b - 8'd32;
        end
      endcase
      stream.push_back(text_byte(b));
    end
  endfunction

  // Ends the stream from inside a sequence or a following header, then adds bytes that must be ignored.
  function automatic void add_terminal();
    logic [7:0] b;
    case ($urandom_range(0, 3))
      0: stream.push_back(eoi_item());
      1: begin
        if ($urandom_range(0, 3) == 0) begin
          case ($urandom_range(0, 3))
            0: b = "j";
            1: b = "o";
            2: b = "J";
            default: b = "O";
          endcase
        end else begin
          do b = 8'($urandom_range(0, 255));
          while (parse_tracker::residue_char(b) || parse_tracker::skip_char(b) ||
                 b == CH_GT);
        end
        stream.push_back(text_byte(b));
      end
      2: begin
        stream.push_back(text_byte(CH_GT));
        add_name();
        stream.push_back(eoi_item());
      end
      default: begin
        stream.push_back(text_byte(CH_GT));
        add_name();
        stream.push_back(text_byte(pick_comment_stop()));
        add_comment();
        stream.push_back(eoi_item());
      end
    endcase
    repeat (6)
      stream.push_back('{data_byte: 8'($urandom_range(0, 255)),
                         end_of_input: 1'($urandom_range(0, 1))});
  endfunction

  task automatic send_stream();
    foreach (stream[i]) begin
      @(negedge clk);
      while ($urandom_range(0, 99) < send_idle_pct) begin
        byte_valid <= 1'b0;
        @(negedge clk);
      end
      byte_valid <= 1'b1;
      byte_data <= stream[i];
      do @(posedge clk); while (!byte_ready);
    end
    @(negedge clk);
    byte_valid <= 1'b0;
  endtask

  // Result side: random stalls, plus a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (byte_valid && byte_ready) tracker.byte_taken(byte_data);
      if (result_valid && result_ready) tracker.result_seen(result_data);
      if ((byte_valid && byte_ready) || (result_valid && result_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    logic [7:0] opening[28] = '{
      CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR, CH_GT,
      CH_COLON, CH_COMMA, CH_SEMI, CH_LPAREN, CH_RPAREN, 8'hFF, 8'h00,
      CH_PIPE, CH_GT, 8'h80, CH_LF,
      "A", "z", CH_DASH, CH_DOT, "9", CH_TAB,
      CH_GT, CH_SLASH, CH_LF, CH_GT
    };
    int phase;

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Leading whitespace, every name substitution, a comment, an empty record.
    foreach (opening[i]) stream.push_back(text_byte(opening[i]));
    send_stream();

    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        1: begin send_idle_pct = 81; stall_pct = 0; end
        2: begin send_idle_pct = 0; stall_pct = 81; end
        3: begin send_idle_pct = 29; stall_pct = 29; end
        default: begin send_idle_pct = 0; stall_pct = 0; end
      endcase
      // Last phase: the receiver holds off while bytes keep coming.
      if (phase == 4) hold_request = 1'b1;
      stream.delete();
      while (stream.size() < PHASE_BYTES) begin
        add_record();
        stream.push_back(text_byte(CH_GT));
      end
      send_stream();
    end

    // A few more records, then one of the ways the stream can end.
    send_idle_pct = 0;
    stall_pct = 0;
    stream.delete();
    repeat (2) begin
      add_record();
      stream.push_back(text_byte(CH_GT));
    end
    add_record();
    add_terminal();
    send_stream();

    while (tracker.expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (tracker.failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/frsp_pkg.sv
rtl/core/frsp_front.sv
rtl/core/frsp_queue.sv
rtl/core/frsp_back.sv
rtl/core/fasta_record_stream_parser.sv
rtl/core/frsp_checker.sv
sim/fasta_record_stream_parser_tb.sv
